// File: rtl/core/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list store
// Operation codes, transaction payload structs and the control word that
// is broadcast along the chain of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  // Default list capacity (entries)
  localparam int DefCapacity = 8;

  localparam int FuncW = 2;
  localparam int PosW  = 4;
  localparam int ValW  = 32;
  localparam int LenW  = 4;

  // Operation codes
  localparam logic [FuncW-1:0] OP_GET    = 2'd0;
  localparam logic [FuncW-1:0] OP_INSERT = 2'd1;
  localparam logic [FuncW-1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic                   success;
    logic signed [ValW-1:0] read_value;
    logic [LenW-1:0]        list_length;
  } rsp_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic            do_insert;  // open a slot at pos_idx, shift upper cells up
    logic            do_delete;  // close the slot at pos_idx, shift upper cells down
    logic [PosW-1:0] pos_idx;    // 0-based target cell
  } cell_ctrl_t;

endpackage : pls_pkg

`default_nettype wire

// File: rtl/core/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed 32-bit entries
// Get, insert and delete at a 1-based position over a chain of list cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with an in_data_i payload
//   (func, position, item_value). Every accepted transaction yields exactly
//   one response transaction on out_valid_o/out_ready_i carrying success,
//   read_value and the list length after the operation.
//   The response is registered at the edge that accepts the request.
//   Throughput is one request per cycle while the receiver takes each
//   response; the whole operation (position check, read of the addressed
//   cell, shift of every cell above it) takes effect at that same edge.
//   When the receiver stalls, the response register holds its transaction
//   and in_ready_o drops until that response is taken; a response that is
//   taken in the same cycle frees the register for the next request.
//   Reset empties the list (length zero) and clears the response valid.
//   Cell contents are not reset; only cells below the length are ever read.
//   Refused requests (bad position, full or empty list, unused opcode)
//   return success 0, read_value 0 and leave the list unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::DefCapacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire pls_pkg::req_t in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      pls_pkg::rsp_t out_data_o
);
  import pls_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  // Length of the list
  logic [CntW-1:0] count_q, count_d;

  // Response register
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  logic accept;
  logic pos_nonzero;
  logic [CmpW-1:0] pos_ext, cnt_ext, len_ext;
  logic in_list;     // position within 1..count
  logic in_gap;      // position within 1..count+1
  logic not_full;
  logic get_ok, ins_ok, del_ok;

  cell_ctrl_t cell_ctrl;

  logic signed [ValW-1:0] cell_val [CAPACITY];
  logic signed [ValW-1:0] rd_chain [CAPACITY+1];

  // Hold a finished response until taken; take a new request when it leaves
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Position checks against the current length
  assign pos_nonzero = (in_data_i.position != '0);
  assign pos_ext     = CmpW'(in_data_i.position);
  assign cnt_ext     = CmpW'(count_q);
  assign in_list     = pos_nonzero && (pos_ext <= cnt_ext);
  assign in_gap      = pos_nonzero && (pos_ext <= (cnt_ext + CmpW'(1)));
  assign not_full    = (count_q < CntW'(CAPACITY));

  always_comb begin
    get_ok = 1'b0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    case (in_data_i.func)
      OP_GET:    get_ok = in_list;
      OP_INSERT: ins_ok = in_gap && not_full;
      OP_DELETE: del_ok = in_list;
      default: begin
        // unused opcode: refuse
      end
    endcase
  end

  // Broadcast to the cells; only a successful, accepted operation moves data
  assign cell_ctrl.do_insert = accept && ins_ok;
  assign cell_ctrl.do_delete = accept && del_ok;
  assign cell_ctrl.pos_idx   = in_data_i.position - PosW'(1);

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] lower_val;
    logic signed [ValW-1:0] upper_val;

    // End cells see the request value at the open side (never read back)
    if (i == 0) begin : g_first
      assign lower_val = in_data_i.item_value;
    end else begin : g_lower
      assign lower_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_val = in_data_i.item_value;
    end else begin : g_upper
      assign upper_val = cell_val[i+1];
    end

    pls_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .ins_value_i(in_data_i.item_value),
      .lower_i    (lower_val),
      .upper_i    (upper_val),
      .rd_chain_i (rd_chain[i]),
      .value_o    (cell_val[i]),
      .rd_chain_o (rd_chain[i+1])
    );
  end

  // Advance the length
  always_comb begin
    count_d = count_q;
    if (accept && ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (accept && del_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign len_ext = CmpW'(count_d);

  // Build the response
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d       = 1'b1;
      out_d.success     = get_ok || ins_ok || del_ok;
      out_d.read_value  = (get_ok || del_ok) ? rd_chain[CAPACITY] : '0;
      out_d.list_length = len_ext[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : positional_list_store

`default_nettype wire

// File: rtl/core/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the positional list
// Holds one entry; on insert or delete it loads the new value or takes the
// entry of its lower or upper neighbor, and it drives its entry onto the
// read chain when it is the addressed cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_cell #(
  parameter int Idx = 0
) (
  input  wire logic                            clk_i,
  input  wire pls_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic signed [pls_pkg::ValW-1:0] ins_value_i,
  input  wire logic signed [pls_pkg::ValW-1:0] lower_i,
  input  wire logic signed [pls_pkg::ValW-1:0] upper_i,
  input  wire logic signed [pls_pkg::ValW-1:0] rd_chain_i,
  output      logic signed [pls_pkg::ValW-1:0] value_o,
  output      logic signed [pls_pkg::ValW-1:0] rd_chain_o
);
  import pls_pkg::*;

  localparam int IdxBits = $clog2(Idx + 1);
  localparam int CmpW    = (IdxBits > PosW) ? IdxBits : PosW;

  logic signed [ValW-1:0] entry_q, entry_d;
  logic                   at_pos;
  logic                   above_pos;

  assign at_pos    = (CmpW'(Idx) == CmpW'(ctrl_i.pos_idx));
  assign above_pos = (CmpW'(Idx) > CmpW'(ctrl_i.pos_idx));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.do_insert) begin
      if (at_pos) begin
        entry_d = ins_value_i;
      end else if (above_pos) begin
        entry_d = lower_i;
      end
    end else if (ctrl_i.do_delete) begin
      if (at_pos || above_pos) begin
        entry_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign value_o    = entry_q;
  assign rd_chain_o = at_pos ? (rd_chain_i | entry_q) : rd_chain_i;

endmodule : pls_cell

`default_nettype wire
